// ===== rtl/slbs_pkg.sv =====
// ----------------------------------------------------------------------------
// slbs_pkg: shared types and pattern ROM for the status LED blink sequencer
// Holds status, command and pattern-kind codes, plus the blink duration table.
// ----------------------------------------------------------------------------
package slbs_pkg;

	localparam int STATUS_W       = 4;
	localparam int CMD_W          = 2;
	localparam int PULSE_W        = 16;
	localparam int ROM_DUR_W      = 16;
	localparam int ROM_IDX_W      = 4;
	localparam int ROM_LEN_W      = 3;

	localparam int DEF_PATTERN_SLOTS = 8;
	localparam int DEF_DURATION_BITS = 16;

	typedef logic [STATUS_W-1:0]  status_t;
	typedef logic [CMD_W-1:0]     cmd_t;
	typedef logic [PULSE_W-1:0]   pulse_t;
	typedef logic [ROM_DUR_W-1:0] rom_dur_t;
	typedef logic [ROM_IDX_W-1:0] rom_idx_t;
	typedef logic [ROM_LEN_W-1:0] rom_len_t;
	typedef logic [1:0]           kind_t;

	// command codes
	localparam cmd_t CMD_TICK  = 2'd0;
	localparam cmd_t CMD_SET   = 2'd1;
	localparam cmd_t CMD_PULSE = 2'd2;

	// status codes
	localparam status_t ST_OFF     = 4'd0;
	localparam status_t ST_BOOT    = 4'd1;
	localparam status_t ST_IDLE    = 4'd2;
	localparam status_t ST_LOGGING = 4'd3;
	localparam status_t ST_SERIAL  = 4'd4;
	localparam status_t ST_SD_ERR  = 4'd5;
	localparam status_t ST_LOW_SPC = 4'd6;
	localparam status_t ST_CLOSING = 4'd7;
	localparam status_t ST_FATAL   = 4'd8;

	// pattern kinds
	localparam kind_t KIND_OFF   = 2'd0;
	localparam kind_t KIND_SOLID = 2'd1;
	localparam kind_t KIND_BLINK = 2'd2;

	typedef struct packed {
		logic    led_level;
		status_t shown_status;
		status_t persistent_status;
	} result_t;

	function automatic kind_t rom_kind(input status_t st);
		kind_t k;
		unique case (st)
			ST_OFF:     k = KIND_OFF;
			ST_LOGGING: k = KIND_SOLID;
			ST_BOOT, ST_IDLE, ST_SERIAL, ST_SD_ERR,
			ST_LOW_SPC, ST_CLOSING, ST_FATAL:
			            k = KIND_BLINK;
			default:    k = KIND_OFF;
		endcase
		return k;
	endfunction

	function automatic rom_len_t rom_len(input status_t st);
		rom_len_t n;
		unique case (st)
			ST_BOOT:    n = 3'd4;
			ST_IDLE:    n = 3'd2;
			ST_SERIAL:  n = 3'd3;
			ST_SD_ERR:  n = 3'd4;
			ST_LOW_SPC: n = 3'd4;
			ST_CLOSING: n = 3'd6;
			ST_FATAL:   n = 3'd2;
			default:    n = 3'd0;
		endcase
		return n;
	endfunction

	// duration in ms of one pattern element; 0 past the end of a list
	function automatic rom_dur_t rom_dur(input status_t st, input rom_idx_t idx);
		rom_dur_t d;
		d = '0;
		unique case (st)
			ST_BOOT: begin
				if (idx == 4'd3) d = 16'd600;
				else if (idx < 4'd3) d = 16'd150;
			end
			ST_IDLE: begin
				if (idx == 4'd0) d = 16'd150;
				else if (idx == 4'd1) d = 16'd1850;
			end
			ST_SERIAL: begin
				if (idx == 4'd2) d = 16'd700;
				else if (idx < 4'd2) d = 16'd150;
			end
			ST_SD_ERR: begin
				if (idx == 4'd3) d = 16'd700;
				else if (idx < 4'd3) d = 16'd150;
			end
			ST_LOW_SPC: begin
				unique case (idx)
					4'd0:    d = 16'd600;
					4'd1:    d = 16'd200;
					4'd2:    d = 16'd150;
					4'd3:    d = 16'd1000;
					default: d = 16'd0;
				endcase
			end
			ST_CLOSING: begin
				if (idx == 4'd5) d = 16'd400;
				else if (idx < 4'd5) d = 16'd80;
			end
			ST_FATAL: begin
				if (idx == 4'd0) d = 16'd2000;
				else if (idx == 4'd1) d = 16'd200;
			end
			default: d = 16'd0;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/status_led_blink_sequencer.sv =====
// ----------------------------------------------------------------------------
// status_led_blink_sequencer: status LED pattern player
// Plays one of nine status patterns from ROM (off, solid or blinking), steps it on 1 ms ticks and shows
// a timed closing pattern that reverts to the last persistent status.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------------
//  input    | in        | in_valid / in_ready | cmd, status, pulse_ms
//  output   | out       | out_valid/out_ready | led_level, shown_status, persistent_status
//  config   | in        | cfg_valid/cfg_ready | cfg_data (active_high)
//
//  One beat in gives one beat out; an item is taken every cycle while in_ready is
//  high, and its result is formed by the single state update and registered in the result
//  register. A skid register behind the result register lets one more beat in
//  while the output stalls; in_ready drops only while the skid register is full.
//  Reset starts the booting pattern from its first element, LED lit, high active.
//  cfg_ready is always high.
//
module status_led_blink_sequencer #(
	parameter int PATTERN_SLOTS = slbs_pkg::DEF_PATTERN_SLOTS,
	parameter int DURATION_BITS = slbs_pkg::DEF_DURATION_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  slbs_pkg::cmd_t    cmd,
	input  slbs_pkg::status_t status,
	input  slbs_pkg::pulse_t  pulse_ms,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              led_level,
	output slbs_pkg::status_t shown_status,
	output slbs_pkg::status_t persistent_status,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);
	import slbs_pkg::*;

	localparam int EL_W = $clog2(PATTERN_SLOTS);

	typedef logic [EL_W-1:0]          el_t;
	typedef logic [EL_W:0]            el_next_t;
	typedef logic [DURATION_BITS-1:0] dur_t;

	// pattern state
	logic    active_high_q;
	status_t cur_q, last_q;
	el_t     idx_q;
	logic    lit_q;
	dur_t    rem_q;
	pulse_t  rev_q;
	logic    armed_q;

	status_t  cur_n, last_n;
	el_t      idx_n;
	logic     lit_n;
	dur_t     rem_n;
	pulse_t   rev_n;
	logic     armed_n;

	status_t  st_in;
	logic     start_en;
	status_t  start_st;
	el_next_t idx_next;
	rom_dur_t start_dur, adv_dur;
	logic     lit_out;
	logic     accept;

	// output buffer
	result_t res_n, main_q, skid_q;
	logic    main_v_q, skid_v_q;

	assign accept    = in_valid & in_ready;
	assign in_ready  = ~skid_v_q;
	assign cfg_ready = 1'b1;

	assign st_in     = (status > ST_FATAL) ? ST_OFF : status;
	assign idx_next  = el_next_t'(idx_q) + el_next_t'(1);
	assign start_dur = rom_dur(start_st, '0);
	assign adv_dur   = rom_dur(cur_q,
		(idx_next >= el_next_t'(rom_len(cur_q)) || idx_next >= el_next_t'(PATTERN_SLOTS))
		? rom_idx_t'(0) : rom_idx_t'(idx_next));

	always_comb begin
		cur_n    = cur_q;
		last_n   = last_q;
		idx_n    = idx_q;
		lit_n    = lit_q;
		rem_n    = rem_q;
		rev_n    = rev_q;
		armed_n  = armed_q;
		start_en = 1'b0;
		start_st = st_in;
		case (cmd)
			CMD_TICK: begin
				if (armed_q && rev_q <= pulse_t'(1)) begin
					// pulse over: back to the persistent pattern
					rev_n    = '0;
					armed_n  = 1'b0;
					start_en = 1'b1;
					start_st = last_q;
				end else begin
					if (armed_q)
						rev_n = rev_q - pulse_t'(1);
					if (rom_kind(cur_q) == KIND_BLINK) begin
						if (rem_q > dur_t'(1)) begin
							rem_n = rem_q - dur_t'(1);
						end else begin
							if (idx_next >= el_next_t'(rom_len(cur_q)) ||
							    idx_next >= el_next_t'(PATTERN_SLOTS)) begin
								idx_n = '0;
								lit_n = 1'b1;
							end else begin
								idx_n = el_t'(idx_next);
								lit_n = ~lit_q;
							end
							rem_n = adv_dur[DURATION_BITS-1:0];
						end
					end
				end
			end
			CMD_SET: begin
				if (st_in != ST_CLOSING) begin
					last_n  = st_in;
					armed_n = 1'b0;
					rev_n   = '0;
				end
				start_en = 1'b1;
			end
			CMD_PULSE: begin
				start_en = 1'b1;
				start_st = ST_CLOSING;
				rev_n    = pulse_ms;
				armed_n  = 1'b1;
			end
			default: ;
		endcase
		if (start_en) begin
			// restart the pattern from its first element
			cur_n = start_st;
			idx_n = '0;
			lit_n = 1'b1;
			rem_n = (rom_kind(start_st) == KIND_BLINK) ? start_dur[DURATION_BITS-1:0] : '0;
		end
	end

	always_comb begin
		unique case (rom_kind(cur_n))
			KIND_SOLID: lit_out = 1'b1;
			KIND_BLINK: lit_out = lit_n;
			default:    lit_out = 1'b0;
		endcase
		res_n.led_level         = active_high_q ? lit_out : ~lit_out;
		res_n.shown_status      = cur_n;
		res_n.persistent_status = last_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_high_q <= 1'b1;
			cur_q         <= ST_BOOT;
			last_q        <= ST_BOOT;
			idx_q         <= '0;
			lit_q         <= 1'b1;
			rem_q         <= dur_t'(rom_dur(ST_BOOT, '0));
			rev_q         <= '0;
			armed_q       <= 1'b0;
		end else begin
			if (cfg_valid)
				active_high_q <= cfg_data;
			if (accept) begin
				cur_q   <= cur_n;
				last_q  <= last_n;
				idx_q   <= idx_n;
				lit_q   <= lit_n;
				rem_q   <= rem_n;
				rev_q   <= rev_n;
				armed_q <= armed_n;
			end
		end
	end

	// result register plus skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (main_v_q && out_ready) begin
			if (skid_v_q)
				skid_v_q <= 1'b0;
			else
				main_v_q <= accept;
		end else if (accept) begin
			if (main_v_q)
				skid_v_q <= 1'b1;
			else
				main_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_v_q && out_ready) begin
			if (skid_v_q)
				main_q <= skid_q;
			else if (accept)
				main_q <= res_n;
		end else if (accept) begin
			if (main_v_q)
				skid_q <= res_n;
			else
				main_q <= res_n;
		end
	end

	assign out_valid         = main_v_q;
	assign led_level         = main_q.led_level;
	assign shown_status      = main_q.shown_status;
	assign persistent_status = main_q.persistent_status;

endmodule
